// ===== src/ptw_pkg.sv =====
// Shared types and constants for the four-level page-table walker.
// Holds the function, status, page-size and state codes and the command/status
// structs between the controller and the datapath; depends on nothing.
`default_nettype none

package ptw_pkg;

  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W             = 9;
  localparam int unsigned ENTRY_W           = 64;
  localparam int unsigned VA_W              = 48;
  localparam int unsigned PA_W              = 52;
  localparam int unsigned FLAGS_W           = 12;
  localparam int unsigned LINK_W            = 40;

  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_LARGE   = 7;

  // Intermediate tables are linked present, writable and user.
  localparam logic [FLAGS_W-1:0] LINK_FLAGS = 12'h007;
  localparam logic [FLAGS_W-1:0] LARGE_FLAG = 12'h080;

  localparam logic [29:0] ALIGN_4K = 30'h0000_0FFF;
  localparam logic [29:0] ALIGN_2M = 30'h001F_FFFF;
  localparam logic [29:0] ALIGN_1G = 30'h3FFF_FFFF;

  typedef enum logic [1:0] {
    FN_QUERY  = 2'd0,
    FN_MAP    = 2'd1,
    FN_CHANGE = 2'd2,
    FN_UNUSED = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MISALIGNED = 3'd1,
    ST_BAD_SIZE   = 3'd2,
    ST_PRESENT    = 3'd3,
    ST_ABSENT     = 3'd4,
    ST_FULL       = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SZ_4K  = 2'd0,
    SZ_2M  = 2'd1,
    SZ_1G  = 2'd2,
    SZ_BAD = 2'd3
  } size_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_READ,
    S_EVAL,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    rd;
    logic    follow;
    logic    wr_link;
    logic    wr_leaf;
    logic    wr_flags;
    logic    done;
    status_t status;
  } ptw_cmd_t;

  // Conditions reported by the datapath to the controller.
  typedef struct packed {
    logic  clearing;
    func_t func;
    logic  misaligned;
    logic  bad_size;
    logic  present;
    logic  big_leaf;
    logic  stray;
    logic  full;
    logic  d_zero;
    logic  d_last;
    logic  d_target;
    logic  out_free;
  } ptw_stat_t;

endpackage

`default_nettype wire

// ===== src/ptw_ctrl.sv =====
// Controller state machine of the page-table walker.
// Sequences checks, table reads, link and leaf writes; uses ptw_pkg.
`default_nettype none

module ptw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  ptw_pkg::ptw_stat_t  stat,
  input  logic                in_valid,
  output logic                in_ready,
  output ptw_pkg::ptw_cmd_t   cmd
);
  import ptw_pkg::*;

  state_t  state, state_next;
  status_t result, result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      result <= ST_OK;
    end else begin
      state  <= state_next;
      result <= result_next;
    end
  end

  always_comb begin
    state_next  = state;
    result_next = result;
    cmd         = '0;
    cmd.status  = result;
    in_ready    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        if (!stat.clearing) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (stat.func)
          FN_QUERY, FN_CHANGE: state_next = S_READ;
          FN_MAP: begin
            priority if (stat.misaligned) begin
              result_next = ST_MISALIGNED;
              state_next  = S_DONE;
            end else if (stat.bad_size) begin
              result_next = ST_BAD_SIZE;
              state_next  = S_DONE;
            end else begin
              state_next = S_READ;
            end
          end
          default: begin
            result_next = ST_BAD_SIZE;
            state_next  = S_DONE;
          end
        endcase
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_DONE;
        if (stat.func == FN_MAP) begin
          priority if (stat.d_target) begin
            if (stat.present) begin
              result_next = ST_PRESENT;
            end else begin
              cmd.wr_leaf = 1'b1;
              result_next = ST_OK;
            end
          end else if (stat.present) begin
            // A large leaf or a pointer past the store blocks the new mapping.
            if ((!stat.d_zero && stat.big_leaf) || stat.stray) begin
              result_next = ST_PRESENT;
            end else begin
              cmd.follow = 1'b1;
              state_next = S_READ;
            end
          end else if (stat.full) begin
            result_next = ST_FULL;
          end else begin
            cmd.wr_link = 1'b1;
            state_next  = S_READ;
          end
        end else begin
          priority if (!stat.present) begin
            result_next = ST_ABSENT;
          end else if (stat.d_last || (!stat.d_zero && stat.big_leaf)) begin
            cmd.wr_flags = (stat.func == FN_CHANGE);
            result_next  = ST_OK;
          end else if (stat.stray) begin
            result_next = ST_ABSENT;
          end else begin
            cmd.follow = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.done   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/ptw_dp.sv =====
// Datapath of the page-table walker: request registers, table memory,
// walk position, table allocator and result register; uses ptw_pkg.
`default_nettype none

module ptw_dp #(
  parameter int unsigned TABLE_PAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ptw_pkg::ptw_cmd_t             cmd,
  output ptw_pkg::ptw_stat_t            stat,
  input  logic [1:0]                    func,
  input  logic [ptw_pkg::VA_W-1:0]      virtual_addr,
  input  logic [ptw_pkg::PA_W-1:0]      phys_addr,
  input  logic [ptw_pkg::FLAGS_W-1:0]   entry_flags,
  input  logic [ptw_pkg::FLAGS_W-1:0]   clear_flags,
  input  logic [1:0]                    leaf_size,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [1:0]                    page_level
);
  import ptw_pkg::*;

  localparam int unsigned PAGE_W = $clog2(TABLE_PAGES);
  localparam int unsigned ADDR_W = PAGE_W + IDX_W;
  localparam int unsigned DEPTH  = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int unsigned NF_W   = $clog2(TABLE_PAGES + 1);

  func_t               func_q;
  size_t               size_q;
  logic [VA_W-1:0]     va_q;
  logic [PA_W-1:0]     pa_q;
  logic [FLAGS_W-1:0]  setf_q;
  logic [FLAGS_W-1:0]  clrf_q;
  logic [PAGE_W-1:0]   page;
  logic [1:0]          lvl;
  logic [NF_W-1:0]     next_free;
  logic                clearing;
  logic [ADDR_W-1:0]   clr_addr;
  status_t             out_status;
  logic [1:0]          out_level;

  // Each word carries a tag: set when its page was already allocated at the
  // time of the write. Allocation clears a page by making untagged words read
  // as zero, so no sweep is needed when a table is created.
  logic [ENTRY_W:0]    mem [DEPTH];
  logic [ENTRY_W:0]    rdata;

  logic [IDX_W-1:0]    idx;
  logic [ADDR_W-1:0]   slot;
  logic                allocated;
  logic [ENTRY_W-1:0]  entry;
  logic [LINK_W-1:0]   link_page;
  logic [29:0]         amask;
  logic [1:0]          target;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ENTRY_W:0]    wr_data;
  logic [FLAGS_W-1:0]  leaf_flags;

  always_comb begin
    unique case (lvl)
      2'd0: idx = va_q[47:39];
      2'd1: idx = va_q[38:30];
      2'd2: idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  always_comb begin
    unique case (size_q)
      SZ_4K: amask = ALIGN_4K;
      SZ_2M: amask = ALIGN_2M;
      SZ_1G: amask = ALIGN_1G;
      default: amask = '0;
    endcase
  end

  assign slot       = {page, idx};
  assign allocated  = NF_W'(page) < next_free;
  assign entry      = (rdata[ENTRY_W] || !allocated) ? rdata[ENTRY_W-1:0] : '0;
  assign link_page  = entry[51:12];
  assign target     = 2'd3 - size_q;
  assign leaf_flags = setf_q | ((size_q != SZ_4K) ? LARGE_FLAG : '0);

  assign stat.clearing   = clearing;
  assign stat.func       = func_q;
  assign stat.misaligned = ((va_q[29:0] & amask) != '0) || ((pa_q[29:0] & amask) != '0);
  assign stat.bad_size   = (size_q == SZ_BAD);
  assign stat.present    = entry[BIT_PRESENT];
  assign stat.big_leaf   = entry[BIT_LARGE];
  assign stat.stray      = link_page >= LINK_W'(TABLE_PAGES);
  assign stat.full       = next_free >= NF_W'(TABLE_PAGES);
  assign stat.d_zero     = (lvl == 2'd0);
  assign stat.d_last     = (lvl == 2'd3);
  assign stat.d_target   = (lvl == target);
  assign stat.out_free   = !out_valid || out_ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot;
    wr_data = '0;
    priority if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
    end else if (cmd.wr_link) begin
      wr_en   = 1'b1;
      // The page being allocated is cleared before its link lands, so a link
      // written into that very page must survive the clear.
      wr_data = {allocated || (NF_W'(page) == next_free),
                 (ENTRY_W - FLAGS_W)'(next_free), LINK_FLAGS};
    end else if (cmd.wr_leaf) begin
      wr_en   = 1'b1;
      wr_data = {allocated, ({12'b0, pa_q} | {52'b0, leaf_flags})};
    end else if (cmd.wr_flags) begin
      wr_en   = 1'b1;
      wr_data = {allocated, entry[ENTRY_W-1:FLAGS_W],
                 (entry[FLAGS_W-1:0] & ~clrf_q) | setf_q};
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rdata <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      next_free <= NF_W'(1);
      out_valid <= 1'b0;
      page      <= '0;
      lvl       <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(DEPTH - 1)) clearing <= 1'b0;
      end
      if (cmd.load) begin
        page <= '0;
        lvl  <= '0;
      end
      if (cmd.follow) begin
        page <= link_page[PAGE_W-1:0];
        lvl  <= lvl + 2'd1;
      end
      if (cmd.wr_link) begin
        page      <= next_free[PAGE_W-1:0];
        lvl       <= lvl + 2'd1;
        next_free <= next_free + NF_W'(1);
      end
      if (cmd.done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func_t'(func);
      size_q <= size_t'(leaf_size);
      va_q   <= virtual_addr;
      pa_q   <= phys_addr;
      setf_q <= entry_flags;
      clrf_q <= clear_flags;
    end
    if (cmd.done) begin
      out_status <= cmd.status;
      out_level  <= (cmd.status == ST_OK) ? lvl : 2'd0;
    end
  end

  assign status     = out_status;
  assign page_level = out_level;

endmodule

`default_nettype wire

// ===== src/four_level_page_table_walker.sv =====
// Top level of the four-level page-table walker.
// Instantiates ptw_ctrl and ptw_dp; uses ptw_pkg.
//
// The walker keeps a four-level page-table store of TABLE_PAGES pages of 512
// 64-bit entries in one single-port on-chip memory, root at page 0, and serves
// one request per item: query a mapping, map a 4KB/2MB/1GB page (creating the
// missing intermediate tables from a bump allocator), or change the low flag
// bits of a leaf. Exactly one result item answers each request. After reset the
// block sweeps the whole memory to zero, one entry a cycle; s_tready stays low
// meanwhile. Items are handled one at a time. An item is taken, then checked,
// then each table level visited costs a memory read and its evaluation (any
// link, leaf or flag write happens in the evaluation step), and last the result
// is handed off, once the output register is free. A request refused by its
// alignment or size check goes straight from the check to the hand-off. Reads
// go through the memory port, which serves one access per cycle with registered
// read data.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module four_level_page_table_walker #(
  parameter int unsigned TABLE_PAGES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // Fields from bit 0: func[1:0].
  input  logic [1:0]   s_tuser,
  // Fields from bit 0: virtual_addr[47:0], phys_addr[99:48],
  // entry_flags[111:100], clear_flags[123:112], leaf_size[125:124], zeros above.
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // Fields from bit 0: status[2:0], page_level[4:3], zeros above.
  output logic [7:0]   m_tdata
);
  import ptw_pkg::*;

  ptw_cmd_t   cmd;
  ptw_stat_t  stat;
  logic [2:0] status;
  logic [1:0] page_level;

  ptw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  ptw_dp #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (s_tuser),
    .virtual_addr (s_tdata[47:0]),
    .phys_addr    (s_tdata[99:48]),
    .entry_flags  (s_tdata[111:100]),
    .clear_flags  (s_tdata[123:112]),
    .leaf_size    (s_tdata[125:124]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .status       (status),
    .page_level   (page_level)
  );

  assign m_tdata = {3'b000, page_level, status};

endmodule

`default_nettype wire

// ===== src/ptw_checker.sv =====
// Port-level checker for the page-table walker, bound to the top level.
// Sees only the top-level ports; depends on four_level_page_table_walker.
`default_nettype none

module ptw_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // A result waiting on the output holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A level is reported exactly when the status is ok.
  a_level_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[2:0] == 3'd0) == (m_tdata[4:3] != 2'd0)))
    else $error("page level disagrees with status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= 3'd5))
    else $error("status code out of range");

  // Only one request is in work at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item taken while another is in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown right after reset");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
